@@ src/bcsc_pkg.sv @@
// Package for the BCD clock setting controller: command and address codes,
// per-field wrap limits and the BCD step function. No dependencies.
`timescale 1ns / 1ps

package bcsc_pkg;

	typedef logic [1:0] cmd_t;
	typedef logic [2:0] addr_t;
	typedef logic [2:0] mode_t;
	typedef logic [7:0] field_t;

	// Command codes.
	localparam cmd_t CMD_MODE = 2'd0;
	localparam cmd_t CMD_UP   = 2'd1;
	localparam cmd_t CMD_DOWN = 2'd2;
	localparam cmd_t CMD_LOAD = 2'd3;

	// Clock chip register addresses.
	localparam addr_t ADDR_SEC   = 3'd0;
	localparam addr_t ADDR_MIN   = 3'd1;
	localparam addr_t ADDR_HOUR  = 3'd2;
	localparam addr_t ADDR_WDAY  = 3'd3;
	localparam addr_t ADDR_DATE  = 3'd4;
	localparam addr_t ADDR_MONTH = 3'd5;
	localparam addr_t ADDR_YEAR  = 3'd6;

	localparam int FIELD_COUNT = 7;

	// Setting modes.
	localparam mode_t MODE_NORMAL = 3'd0;
	localparam mode_t MODE_SEC    = 3'd1;
	localparam mode_t MODE_MIN    = 3'd2;
	localparam mode_t MODE_HOUR   = 3'd3;
	localparam mode_t MODE_YEAR   = 3'd4;
	localparam mode_t MODE_MONTH  = 3'd5;
	localparam mode_t MODE_DATE   = 3'd6;
	localparam mode_t MODE_WDAY   = 3'd7;

	// Register address that each setting mode adjusts.
	function automatic addr_t mode_addr(input mode_t mode);
		addr_t a;
		case (mode)
			MODE_SEC:   a = ADDR_SEC;
			MODE_MIN:   a = ADDR_MIN;
			MODE_HOUR:  a = ADDR_HOUR;
			MODE_YEAR:  a = ADDR_YEAR;
			MODE_MONTH: a = ADDR_MONTH;
			MODE_DATE:  a = ADDR_DATE;
			MODE_WDAY:  a = ADDR_WDAY;
			default:    a = ADDR_SEC;
		endcase
		return a;
	endfunction

	// Lowest value of a field, where a downward step wraps.
	function automatic field_t field_low(input addr_t addr);
		field_t v;
		case (addr) inside
			ADDR_WDAY:              v = 8'd2;
			ADDR_DATE, ADDR_MONTH:  v = 8'h01;
			default:                v = 8'h00;
		endcase
		return v;
	endfunction

	// Highest value of a field, where an upward step wraps.
	function automatic field_t field_high(input addr_t addr);
		field_t v;
		case (addr) inside
			ADDR_SEC, ADDR_MIN: v = 8'h59;
			ADDR_HOUR:          v = 8'h23;
			ADDR_WDAY:          v = 8'd8;
			ADDR_DATE:          v = 8'h31;
			ADDR_MONTH:         v = 8'h12;
			default:            v = 8'h99;
		endcase
		return v;
	endfunction

	// Step a two-digit BCD value by one through its binary value. The split
	// back into digits divides by ten through a multiply by 205 and a shift,
	// which is exact for all eight-bit values.
	function automatic field_t bcd_step(input field_t x, input logic down);
		logic [7:0]  bin;
		logic [15:0] prod;
		logic [4:0]  tens;
		logic [7:0]  units;
		bin   = 8'(({4'd0, x[7:4]} * 8'd10) + {4'd0, x[3:0]});
		bin   = down ? bin - 8'd1 : bin + 8'd1;
		prod  = {8'd0, bin} * 16'd205;
		tens  = prod[15:11];
		units = bin - 8'({3'd0, tens} * 8'd10);
		return {tens[3:0], units[3:0]};
	endfunction

endpackage

@@ src/bcd_clock_setting_controller.sv @@
// BCD clock setting controller: mode register, seven time registers and the
// step logic with input and result registers. Depends on bcsc_pkg.
`timescale 1ns / 1ps

// Usage
// The input channel (in_valid/in_ready) carries one command word: a mode
// key, an up key, a down key or a load of a value read back from the clock
// chip. Every accepted word produces exactly one result word on the output
// channel (out_valid/out_ready): a write request (write_valid, address and
// new field value) and the setting mode after the command.
// A word is captured in an input register; from there the field selected
// by the mode is stepped in one pass of logic and the result is
// registered in the result register. One word is accepted per cycle in
// steady flow; the state is updated as the word moves into the result
// register, so the following word sees it at once.
// While the receiver stalls, the result register holds its word and the
// input register can still take one more word; after that in_ready drops
// until the result is taken.
// Reset clears the mode to normal, all time registers to zero and empties
// both registers.
module bcd_clock_setting_controller (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  bcsc_pkg::cmd_t       command,
	input  bcsc_pkg::addr_t      load_address,
	input  bcsc_pkg::field_t     load_value,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 write_valid,
	output bcsc_pkg::addr_t      write_address,
	output bcsc_pkg::field_t     write_data,
	output bcsc_pkg::mode_t      setting_mode
);
	import bcsc_pkg::*;

	// Input register.
	logic   valid_s1;
	cmd_t   command_s1;
	addr_t  load_address_s1;
	field_t load_value_s1;

	// Block state.
	mode_t  mode_q;
	field_t time_fields_q [FIELD_COUNT];

	// Result register.
	logic   out_valid_q;
	logic   write_valid_q;
	addr_t  write_address_q;
	field_t write_data_q;
	mode_t  setting_mode_q;

	logic   advance;
	addr_t  step_addr;
	field_t cur_value;
	field_t step_value;
	logic   step_down;
	logic   do_step;
	logic   do_load;
	mode_t  next_mode;

	// The word in the input register moves on when the result slot is free.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			command_s1      <= command;
			load_address_s1 <= load_address;
			load_value_s1   <= load_value;
		end
	end

	// Step of the field that the current mode selects.
	assign step_addr = mode_addr(mode_q);
	assign cur_value = time_fields_q[step_addr];
	assign step_down = (command_s1 == CMD_DOWN);
	assign do_step   = (command_s1 == CMD_UP || command_s1 == CMD_DOWN) &&
		(mode_q != MODE_NORMAL);
	assign do_load   = (command_s1 == CMD_LOAD) && (load_address_s1 <= ADDR_YEAR);
	assign next_mode = (command_s1 == CMD_MODE) ? mode_q + 3'd1 : mode_q;

	always_comb begin
		if (!step_down && cur_value == field_high(step_addr)) begin
			step_value = field_low(step_addr);
		end else if (step_down && cur_value == field_low(step_addr)) begin
			step_value = field_high(step_addr);
		end else if (step_addr == ADDR_WDAY) begin
			step_value = step_down ? cur_value - 8'd1 : cur_value + 8'd1;
		end else begin
			step_value = bcd_step(cur_value, step_down);
		end
	end

	// State update as the word leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			for (int i = 0; i < FIELD_COUNT; i++) begin
				time_fields_q[i] <= '0;
			end
		end else if (advance) begin
			mode_q <= next_mode;
			if (do_load) begin
				time_fields_q[load_address_s1] <= load_value_s1;
			end else if (do_step) begin
				time_fields_q[step_addr] <= step_value;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			write_valid_q   <= do_step;
			write_address_q <= do_step ? step_addr : ADDR_SEC;
			write_data_q    <= do_step ? step_value : 8'h00;
			setting_mode_q  <= next_mode;
		end
	end

	assign out_valid     = out_valid_q;
	assign write_valid   = write_valid_q;
	assign write_address = write_address_q;
	assign write_data    = write_data_q;
	assign setting_mode  = setting_mode_q;

endmodule

@@ src/bcsc_checker.sv @@
// Port-level checks for the BCD clock setting controller, bound to the top
// level. Depends on bcsc_pkg.
`timescale 1ns / 1ps

module bcsc_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_ready,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 write_valid,
	input  bcsc_pkg::addr_t      write_address,
	input  bcsc_pkg::field_t     write_data,
	input  bcsc_pkg::mode_t      setting_mode
);
	import bcsc_pkg::*;

	// A stalled result word holds still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(write_data) &&
		$stable(write_address) && $stable(write_valid) && $stable(setting_mode))
		else $error("stalled result word changed");

	// No write request leaves the block in normal mode.
	a_no_write_normal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_valid |-> setting_mode != MODE_NORMAL)
		else $error("write request in normal mode");

	// A word without a write carries a zero address and zero data.
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_valid |-> write_address == ADDR_SEC && write_data == 8'h00)
		else $error("non-write word carries address or data");

	// The write address is the one that the reported mode adjusts.
	a_addr_of_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_valid |-> write_address == mode_addr(setting_mode))
		else $error("write address does not match setting mode");

	// An empty result slot always leaves room for a new word.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result slot");

endmodule

bind bcd_clock_setting_controller bcsc_checker u_bcsc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.write_valid   (write_valid),
	.write_address (write_address),
	.write_data    (write_data),
	.setting_mode  (setting_mode)
);
